### rtl/rvdec_pkg.sv
// Shared types and encoding constants for the RV32IM instruction decoder.
package rvdec_pkg;

    // Major opcodes
    localparam logic [6:0] OPC_R      = 7'h33;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_LUI    = 7'h37;

    // funct7 values
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // Instruction formats
    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_R    = 3'd1;
    localparam logic [2:0] FMT_I    = 3'd2;
    localparam logic [2:0] FMT_S    = 3'd3;
    localparam logic [2:0] FMT_SB   = 3'd4;
    localparam logic [2:0] FMT_U    = 3'd5;
    localparam logic [2:0] FMT_UJ   = 3'd6;

    // ALU operations
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_REM  = 4'd4;
    localparam logic [3:0] OP_SLL  = 4'd5;
    localparam logic [3:0] OP_SLT  = 4'd6;
    localparam logic [3:0] OP_SLTU = 4'd7;
    localparam logic [3:0] OP_XOR  = 4'd8;
    localparam logic [3:0] OP_SRL  = 4'd9;
    localparam logic [3:0] OP_SRA  = 4'd10;
    localparam logic [3:0] OP_OR   = 4'd11;
    localparam logic [3:0] OP_AND  = 4'd12;

    // funct3 codes used in ALU selection
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Control flag masks
    localparam logic [6:0] FL_NONE     = 7'h00;
    localparam logic [6:0] FL_BRANCH   = 7'h01;
    localparam logic [6:0] FL_MEMREAD  = 7'h02;
    localparam logic [6:0] FL_MEMTOREG = 7'h04;
    localparam logic [6:0] FL_MEMWRITE = 7'h08;
    localparam logic [6:0] FL_ALUSRC   = 7'h10;
    localparam logic [6:0] FL_REGWRITE = 7'h20;
    localparam logic [6:0] FL_JUMP     = 7'h40;

    typedef struct packed {
        logic [6:0]         opcode;
        logic [4:0]         rd;
        logic [2:0]         funct3;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic [6:0]         funct7;
        logic [2:0]         fmt;
        logic signed [31:0] imm;
        logic [3:0]         alu_op;
        logic [6:0]         flags;
    } dec_t;

endpackage

### rtl/rv32im_instruction_decoder.sv
// Throughput: one item per cycle; an input register, the decode logic and the
// result register form a two-stage pipeline, and the input stalls only when both
// registers hold items and the consumer stalls.
// Reset: asynchronous, active low; clears the stage valid bits, data is not reset.
module rv32im_instruction_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instruction_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [6:0]         opcode_field,
    output logic [4:0]         dest_reg,
    output logic [2:0]         funct3_field,
    output logic [4:0]         src1_reg,
    output logic [4:0]         src2_reg,
    output logic [6:0]         funct7_field,
    output logic [2:0]         format_kind,
    output logic signed [31:0] immediate,
    output logic [3:0]         alu_operation,
    output logic [6:0]         control_flags
);

    logic            word_valid_reg;
    logic            word_valid_next;
    logic [31:0]     word_reg;
    logic            out_ready;
    rvdec_pkg::dec_t dec;
    rvdec_pkg::dec_t res;

    assign in_stall = word_valid_reg && !out_ready;

    always_comb
    begin
        word_valid_next = word_valid_reg;
        if (!in_stall)
            word_valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_valid_reg <= 1'b0;
        else
            word_valid_reg <= word_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            word_reg <= instruction_word;
    end

    rvdec_decode u_decode
    (
        .word (word_reg),
        .dec  (dec)
    );

    rvdec_out_stage u_out
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (word_valid_reg),
        .d     (dec),
        .stall (out_stall),
        .ready (out_ready),
        .valid (out_valid),
        .q     (res)
    );

    assign opcode_field  = res.opcode;
    assign dest_reg      = res.rd;
    assign funct3_field  = res.funct3;
    assign src1_reg      = res.rs1;
    assign src2_reg      = res.rs2;
    assign funct7_field  = res.funct7;
    assign format_kind   = res.fmt;
    assign immediate     = res.imm;
    assign alu_operation = res.alu_op;
    assign control_flags = res.flags;

endmodule

### rtl/rvdec_decode.sv
// Combinational decode of one instruction word into fields, immediate, ALU op and flags.
module rvdec_decode
(
    input  logic [31:0]        word,
    output rvdec_pkg::dec_t    dec
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] i_imm;
    logic [31:0] s_imm;
    logic [31:0] b_imm;
    logic [31:0] j_imm;
    logic [31:0] u_imm;
    logic [3:0]  r_op;
    logic [3:0]  imm_op;
    logic [3:0]  br_op;
    logic [3:0]  sr_op;

    assign opc = word[6:0];
    assign f3  = word[14:12];
    assign f7  = word[31:25];

    assign i_imm = {{20{word[31]}}, word[31:20]};
    assign s_imm = {{20{word[31]}}, word[31:25], word[11:7]};
    assign b_imm = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign j_imm = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    assign u_imm = {word[31:12], 12'h000};

    // Right shifts share one rule for register and immediate forms.
    always_comb
    begin
        if (f7 == rvdec_pkg::F7_BASE)
            sr_op = rvdec_pkg::OP_SRL;
        else if (f7 == rvdec_pkg::F7_ALT)
            sr_op = rvdec_pkg::OP_SRA;
        else
            sr_op = rvdec_pkg::OP_ADD;
    end

    always_comb
    begin
        unique case (f3)
            rvdec_pkg::F3_ADD:
            begin
                if (f7 == rvdec_pkg::F7_ALT)
                    r_op = rvdec_pkg::OP_SUB;
                else if (f7 == rvdec_pkg::F7_MULDIV)
                    r_op = rvdec_pkg::OP_MUL;
                else
                    r_op = rvdec_pkg::OP_ADD;
            end
            rvdec_pkg::F3_SLL:  r_op = rvdec_pkg::OP_SLL;
            rvdec_pkg::F3_SLT:  r_op = rvdec_pkg::OP_SLT;
            rvdec_pkg::F3_SLTU: r_op = rvdec_pkg::OP_SLTU;
            rvdec_pkg::F3_XOR:
            begin
                if (f7 == rvdec_pkg::F7_BASE)
                    r_op = rvdec_pkg::OP_XOR;
                else if (f7 == rvdec_pkg::F7_MULDIV)
                    r_op = rvdec_pkg::OP_DIV;
                else
                    r_op = rvdec_pkg::OP_ADD;
            end
            rvdec_pkg::F3_SR:   r_op = sr_op;
            rvdec_pkg::F3_OR:
            begin
                if (f7 == rvdec_pkg::F7_BASE)
                    r_op = rvdec_pkg::OP_OR;
                else if (f7 == rvdec_pkg::F7_MULDIV)
                    r_op = rvdec_pkg::OP_REM;
                else
                    r_op = rvdec_pkg::OP_ADD;
            end
            rvdec_pkg::F3_AND:  r_op = rvdec_pkg::OP_AND;
            default:            r_op = rvdec_pkg::OP_ADD;
        endcase
    end

    always_comb
    begin
        unique case (f3)
            rvdec_pkg::F3_ADD:  imm_op = rvdec_pkg::OP_ADD;
            rvdec_pkg::F3_SLL:  imm_op = rvdec_pkg::OP_SLL;
            rvdec_pkg::F3_SLT:  imm_op = rvdec_pkg::OP_SLT;
            rvdec_pkg::F3_SLTU: imm_op = rvdec_pkg::OP_SLTU;
            rvdec_pkg::F3_XOR:  imm_op = rvdec_pkg::OP_XOR;
            rvdec_pkg::F3_SR:   imm_op = sr_op;
            rvdec_pkg::F3_OR:   imm_op = rvdec_pkg::OP_OR;
            rvdec_pkg::F3_AND:  imm_op = rvdec_pkg::OP_AND;
            default:            imm_op = rvdec_pkg::OP_ADD;
        endcase
    end

    // Branch compares: equality tests subtract, ordered tests use the set-less-than ops.
    always_comb
    begin
        unique case (f3[2:1])
            2'b00:   br_op = rvdec_pkg::OP_SUB;
            2'b10:   br_op = rvdec_pkg::OP_SLT;
            2'b11:   br_op = rvdec_pkg::OP_SLTU;
            default: br_op = rvdec_pkg::OP_ADD;
        endcase
    end

    always_comb
    begin
        dec.opcode = opc;
        dec.rd     = word[11:7];
        dec.funct3 = f3;
        dec.rs1    = word[19:15];
        dec.rs2    = word[24:20];
        dec.funct7 = f7;
        dec.fmt    = rvdec_pkg::FMT_NONE;
        dec.imm    = 32'sd0;
        dec.alu_op = rvdec_pkg::OP_ADD;
        dec.flags  = rvdec_pkg::FL_NONE;
        unique case (opc)
            rvdec_pkg::OPC_R:
            begin
                dec.fmt    = rvdec_pkg::FMT_R;
                dec.alu_op = r_op;
                dec.flags  = rvdec_pkg::FL_REGWRITE;
            end
            rvdec_pkg::OPC_LOAD:
            begin
                dec.fmt   = rvdec_pkg::FMT_I;
                dec.imm   = $signed(i_imm);
                dec.flags = rvdec_pkg::FL_ALUSRC | rvdec_pkg::FL_MEMREAD
                          | rvdec_pkg::FL_MEMTOREG | rvdec_pkg::FL_REGWRITE;
            end
            rvdec_pkg::OPC_OPIMM:
            begin
                dec.fmt    = rvdec_pkg::FMT_I;
                dec.imm    = $signed(i_imm);
                dec.alu_op = imm_op;
                dec.flags  = rvdec_pkg::FL_ALUSRC | rvdec_pkg::FL_REGWRITE;
            end
            rvdec_pkg::OPC_JALR:
            begin
                dec.fmt   = rvdec_pkg::FMT_I;
                dec.imm   = $signed(i_imm);
                dec.flags = rvdec_pkg::FL_ALUSRC | rvdec_pkg::FL_REGWRITE
                          | rvdec_pkg::FL_JUMP;
            end
            rvdec_pkg::OPC_SYSTEM:
            begin
                dec.fmt = rvdec_pkg::FMT_I;
                dec.imm = $signed(i_imm);
            end
            rvdec_pkg::OPC_STORE:
            begin
                dec.fmt   = rvdec_pkg::FMT_S;
                dec.imm   = $signed(s_imm);
                dec.flags = rvdec_pkg::FL_MEMWRITE | rvdec_pkg::FL_ALUSRC;
            end
            rvdec_pkg::OPC_BRANCH:
            begin
                dec.fmt    = rvdec_pkg::FMT_SB;
                dec.imm    = $signed(b_imm);
                dec.alu_op = br_op;
                dec.flags  = rvdec_pkg::FL_BRANCH;
            end
            rvdec_pkg::OPC_JAL:
            begin
                dec.fmt   = rvdec_pkg::FMT_UJ;
                dec.imm   = $signed(j_imm);
                dec.flags = rvdec_pkg::FL_ALUSRC | rvdec_pkg::FL_REGWRITE
                          | rvdec_pkg::FL_JUMP;
            end
            rvdec_pkg::OPC_AUIPC, rvdec_pkg::OPC_LUI:
            begin
                dec.fmt   = rvdec_pkg::FMT_U;
                dec.imm   = $signed(u_imm);
                dec.flags = rvdec_pkg::FL_REGWRITE | rvdec_pkg::FL_ALUSRC;
            end
            default:
            begin
                dec.fmt = rvdec_pkg::FMT_NONE;
            end
        endcase
    end

endmodule

### rtl/rvdec_out_stage.sv
// Result register with valid/stall handshake toward the consumer.
module rvdec_out_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  rvdec_pkg::dec_t d,
    input  logic            stall,
    output logic            ready,
    output logic            valid,
    output rvdec_pkg::dec_t q
);

    logic            valid_reg;
    logic            valid_next;
    rvdec_pkg::dec_t data_reg;

    // The register can take a new item when empty or when its item leaves this cycle.
    assign ready = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
            valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
            data_reg <= d;
    end

    assign valid = valid_reg;
    assign q     = data_reg;

endmodule

### rtl/rvdec_checker.sv
// Port-level checks for the instruction decoder and the bind that attaches them.
module rvdec_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [6:0]         opcode_field,
    input logic [2:0]         format_kind,
    input logic signed [31:0] immediate,
    input logic [3:0]         alu_operation,
    input logic [6:0]         control_flags
);

    // A held result stays presented.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Back-pressure reaches the input only when a result is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // An unrecognized opcode yields a neutral decode.
    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && format_kind == rvdec_pkg::FMT_NONE |->
        immediate == 32'sd0 && control_flags == rvdec_pkg::FL_NONE
        && alu_operation == rvdec_pkg::OP_ADD)
        else $error("unknown opcode decoded with side effects");

    // Register-register items carry no immediate and only write the register file.
    a_rtype: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && opcode_field == rvdec_pkg::OPC_R |->
        format_kind == rvdec_pkg::FMT_R && immediate == 32'sd0
        && control_flags == rvdec_pkg::FL_REGWRITE)
        else $error("R-type decode mismatch");

endmodule

bind rv32im_instruction_decoder rvdec_checker u_rvdec_checker (.*);
